// File: rtl/pmba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmba_pkg
// Shared types and constants of the physical memory bump allocator.
// ----------------------------------------------------------------------------
package pmba_pkg;

  // Table depth and derived widths
  localparam int MAX_BLOCKS = 64;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  // Field widths
  localparam int PA_W   = 40;            // physical address / length
  localparam int HW_W   = PA_W + 1;      // high-water mark
  localparam int POS_W  = PA_W + 2;      // aligned start before the window check
  localparam int END_W  = PA_W + 3;      // aligned start plus length
  localparam int VA_W   = 48;
  localparam int KIND_W = 4;
  localparam int PROT_W = 8;
  localparam int MODE_W = 4;
  localparam int PM_W   = PROT_W + MODE_W;
  localparam int ERR_W  = 3;

  // Remainder unit step count
  localparam int DIV_STEPS = HW_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // Stream packing
  localparam int IN_TDATA_W  = 264;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_MAP   = 1'b1
  } opcode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK      = 3'd0,
    ERR_WINDOW  = 3'd1,
    ERR_FULL    = 3'd2,
    ERR_NOBLOCK = 3'd3,
    ERR_MAPPED  = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACHK,
    ST_SCAN,
    ST_MUPD,
    ST_RESP
  } state_t;

  // One table entry; prot_mode holds protection in the upper bits
  typedef struct packed {
    logic [PA_W-1:0]   start;
    logic [PA_W-1:0]   size;
    logic [KIND_W-1:0] kind;
    logic [VA_W-1:0]   map_virt;
    logic [PA_W-1:0]   bind_len;
    logic [PM_W-1:0]   prot_mode;
  } blk_t;

endpackage

// File: rtl/pmba_rem_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmba_rem_unit
// Restoring remainder unit over all DIV_STEPS dividend bits, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pmba_rem_unit
  import pmba_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [HW_W-1:0] dividend,
  input  logic [PA_W-1:0] divisor,    // nonzero
  output logic            done,
  output logic [PA_W-1:0] rem
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [PA_W-1:0]   rem_r, rem_nxt;
  logic [HW_W-1:0]   dvd_r, dvd_nxt;
  logic [PA_W-1:0]   dvs_r, dvs_nxt;
  logic [PA_W:0]     trial;
  logic [PA_W:0]     diff;

  // One restoring step: shift in the next bit, subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[HW_W-1]};
    diff  = trial - {1'b0, dvs_r};
  end

  // Advance the iteration
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIV_STEPS);
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[PA_W-1:0] : trial[PA_W-1:0];
      dvd_nxt = {dvd_r[HW_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/phys_memory_bump_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phys_memory_bump_allocator_top
// Bump allocator over a table of physical blocks, with block mapping.
// ----------------------------------------------------------------------------
// One word is handled at a time and gives exactly one result word. An
// allocate word is paced by the 41-step remainder unit that aligns the
// high-water mark. A map word reads table entries up to and including the
// containing block (all entries when none contains the address), paced by
// the single read port of the block table, which yields one entry per
// cycle. A new word is accepted while the previous result still waits on
// the output register. The block table needs no clearing after reset: only
// entries below the block count are ever read.
// ----------------------------------------------------------------------------
module phys_memory_bump_allocator_top
  import pmba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // search_start[39:0], search_end[79:40], length[119:80], align_bytes[159:120],
  // mem_kind[163:160], virt_base[211:164], phys_probe[251:212],
  // protection[259:252], access_mode[263:260]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,   // opcode[0]
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // success[0], alloc_addr[40:1], error_code[43:41], zero fill[47:44]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Request fields
  logic [PA_W-1:0]   f_sstart, f_send, f_len, f_align, f_probe;
  logic [KIND_W-1:0] f_kind;
  logic [VA_W-1:0]   f_virt;
  logic [PROT_W-1:0] f_prot;
  logic [MODE_W-1:0] f_mode;

  assign f_sstart = in_tdata[39:0];
  assign f_send   = in_tdata[79:40];
  assign f_len    = in_tdata[119:80];
  assign f_align  = in_tdata[159:120];
  assign f_kind   = in_tdata[163:160];
  assign f_virt   = in_tdata[211:164];
  assign f_probe  = in_tdata[251:212];
  assign f_prot   = in_tdata[259:252];
  assign f_mode   = in_tdata[263:260];

  state_t state_r, state_nxt;

  // Held request
  logic [PA_W-1:0]   sstart_r, send_r, len_r, align_r, probe_r;
  logic [KIND_W-1:0] kind_r;
  logic [VA_W-1:0]   virt_r;
  logic [PM_W-1:0]   pm_r;

  // Allocator state
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [HW_W-1:0]   hw_r, hw_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              pos_vld_r, pos_vld_nxt;

  // Scan pipeline
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [ADDR_W-1:0] chk_idx_r, chk_idx_nxt;

  // Pending result
  logic              res_ok_r, res_ok_nxt;
  logic [PA_W-1:0]   res_addr_r, res_addr_nxt;
  err_t              res_err_r, res_err_nxt;

  // Output register
  logic              out_vld_r, out_vld_nxt;
  logic              out_ok_r;
  logic [PA_W-1:0]   out_addr_r;
  err_t              out_err_r;

  // Block table
  blk_t              mem [MAX_BLOCKS];
  blk_t              rd_data_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  blk_t              mem_wdata;

  // Remainder unit
  logic              div_start, div_done;
  logic [PA_W-1:0]   div_rem;
  logic [PA_W-1:0]   align_eff;

  logic              accept, out_load;
  logic [END_W-1:0]  end_sum;
  logic              win_bad, tbl_full;
  logic [PA_W:0]     blk_lim;
  logic              hit, blk_mapped;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_RESP) && (!out_vld_r || out_tready);
  assign align_eff = (f_align == '0) ? PA_W'(1) : f_align;
  assign div_start = accept && (in_tuser == OP_ALLOC);

  pmba_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (hw_r),
    .divisor  (align_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Window and capacity checks on the aligned start
  always_comb begin
    end_sum  = END_W'(pos_r) + END_W'(len_r);
    win_bad  = (pos_r < POS_W'(sstart_r)) || (end_sum > END_W'(send_r));
    tbl_full = (cnt_r >= CNT_W'(MAX_BLOCKS));
  end

  // Containment test on the entry read last cycle
  always_comb begin
    blk_lim    = {1'b0, rd_data_r.start} + {1'b0, rd_data_r.size};
    hit        = chk_vld_r && (probe_r >= rd_data_r.start) &&
                 ({1'b0, probe_r} < blk_lim);
    blk_mapped = (rd_data_r.map_virt != '0) || (rd_data_r.bind_len != '0);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = (in_tuser == OP_ALLOC) ? ST_DIV : ST_SCAN;
      end
      ST_DIV: begin
        if (pos_vld_r) state_nxt = ST_ACHK;
      end
      ST_ACHK: state_nxt = ST_RESP;
      ST_SCAN: begin
        if (hit) state_nxt = ST_MUPD;
        else if (!mem_re && !chk_vld_r) state_nxt = ST_RESP;
      end
      ST_MUPD: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and table access per state
  always_comb begin
    cnt_nxt      = cnt_r;
    hw_nxt       = hw_r;
    pos_nxt      = pos_r;
    pos_vld_nxt  = 1'b0;
    idx_nxt      = idx_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    res_ok_nxt   = res_ok_r;
    res_addr_nxt = res_addr_r;
    res_err_nxt  = res_err_r;
    mem_we       = 1'b0;
    mem_waddr    = cnt_r[ADDR_W-1:0];
    mem_wdata    = rd_data_r;
    mem_re       = 1'b0;
    mem_raddr    = idx_r[ADDR_W-1:0];
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
      end
      ST_DIV: begin
        // Round the high-water mark up to the alignment
        if (div_done) begin
          pos_vld_nxt = 1'b1;
          if (div_rem == '0) pos_nxt = POS_W'(hw_r);
          else pos_nxt = POS_W'(hw_r) - POS_W'(div_rem) + POS_W'(align_r);
        end
      end
      ST_ACHK: begin
        res_ok_nxt   = 1'b0;
        res_addr_nxt = '0;
        if (win_bad) begin
          res_err_nxt = ERR_WINDOW;
        end else if (tbl_full) begin
          res_err_nxt = ERR_FULL;
        end else begin
          // Append an unmapped block
          mem_we              = 1'b1;
          mem_wdata.start     = pos_r[PA_W-1:0];
          mem_wdata.size      = len_r;
          mem_wdata.kind      = kind_r;
          mem_wdata.map_virt  = '0;
          mem_wdata.bind_len  = '0;
          mem_wdata.prot_mode = '0;
          cnt_nxt             = cnt_r + 1'b1;
          if (end_sum > END_W'(hw_r)) hw_nxt = end_sum[HW_W-1:0];
          res_ok_nxt   = 1'b1;
          res_addr_nxt = pos_r[PA_W-1:0];
          res_err_nxt  = ERR_OK;
        end
      end
      ST_SCAN: begin
        // Read one entry per cycle, test it the cycle after
        mem_re = (idx_r < cnt_r) && !hit;
        if (mem_re) begin
          idx_nxt     = idx_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r[ADDR_W-1:0];
        end
        res_ok_nxt   = 1'b0;
        res_addr_nxt = '0;
        res_err_nxt  = ERR_NOBLOCK;
      end
      ST_MUPD: begin
        res_addr_nxt = '0;
        if (blk_mapped) begin
          res_ok_nxt  = 1'b0;
          res_err_nxt = ERR_MAPPED;
        end else begin
          // Write back the found entry with the mapping
          mem_we              = 1'b1;
          mem_waddr           = chk_idx_r;
          mem_wdata.map_virt  = virt_r;
          mem_wdata.bind_len  = len_r;
          mem_wdata.prot_mode = pm_r;
          res_ok_nxt          = 1'b1;
          res_err_nxt         = ERR_OK;
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_tready) out_vld_nxt = 1'b0;
    if (out_load) out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      hw_r      <= '0;
      pos_vld_r <= 1'b0;
      chk_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      hw_r      <= hw_nxt;
      pos_vld_r <= pos_vld_nxt;
      chk_vld_r <= chk_vld_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sstart_r <= f_sstart;
      send_r   <= f_send;
      len_r    <= f_len;
      align_r  <= align_eff;
      probe_r  <= f_probe;
      kind_r   <= f_kind;
      virt_r   <= f_virt;
      pm_r     <= {f_prot, f_mode};
    end
    pos_r      <= pos_nxt;
    chk_idx_r  <= chk_idx_nxt;
    res_ok_r   <= res_ok_nxt;
    res_addr_r <= res_addr_nxt;
    res_err_r  <= res_err_nxt;
    if (out_load) begin
      out_ok_r   <= res_ok_r;
      out_addr_r <= res_addr_r;
      out_err_r  <= res_err_r;
    end
  end

  // Block table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_err_r, out_addr_r, out_ok_r};

  // Checks
  property p_cnt_bound;
    @(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(MAX_BLOCKS);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound)
    else $error("block count beyond table depth");

  property p_busy_after_accept;
    @(posedge clk) disable iff (!rst_n) accept |=> (state_r != ST_IDLE);
  endproperty
  a_busy_after_accept: assert property (p_busy_after_accept)
    else $error("accepted word left no work in progress");

  property p_div_in_state;
    @(posedge clk) disable iff (!rst_n) div_done |-> (state_r == ST_DIV);
  endproperty
  a_div_in_state: assert property (p_div_in_state)
    else $error("remainder finished outside the align step");

  property p_ok_code;
    @(posedge clk) disable iff (!rst_n)
      out_load |=> (out_ok_r == (out_err_r == ERR_OK));
  endproperty
  a_ok_code: assert property (p_ok_code)
    else $error("success flag disagrees with error code");

  property p_hw_grows;
    @(posedge clk) disable iff (!rst_n)
      (state_r != ST_ACHK) |=> (hw_r == $past(hw_r));
  endproperty
  a_hw_grows: assert property (p_hw_grows)
    else $error("high-water mark moved outside an allocate commit");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the physical memory bump allocator.
// ----------------------------------------------------------------------------
// Request words come from a queue that the stimulus block fills. That block
// runs its own model of the block table, so map probes can aim at blocks
// that exist. The driver sends the words in bursts with random gaps. The
// monitor stalls the result stream on its own changing pattern and checks
// each result word against the oldest predicted one, field by field. A
// directed part covers alignment, window edges, zero-length blocks and
// mapped/unmapped cases. A random part of well-formed and noise words
// follows, and a tail fills the table to show the table-full error.
// ----------------------------------------------------------------------------
module testbench;
  import pmba_pkg::*;

  localparam logic [PA_W-1:0] PA_MAX = {PA_W{1'b1}};
  localparam logic [VA_W-1:0] VA_MAX = {VA_W{1'b1}};

  // Request layout: opcode on top, then the in_tdata fields, first field lowest
  typedef struct packed {
    opcode_t           op;
    logic [MODE_W-1:0] access_mode;
    logic [PROT_W-1:0] protection;
    logic [PA_W-1:0]   phys_probe;
    logic [VA_W-1:0]   virt_base;
    logic [KIND_W-1:0] mem_kind;
    logic [PA_W-1:0]   align_bytes;
    logic [PA_W-1:0]   length;
    logic [PA_W-1:0]   search_end;
    logic [PA_W-1:0]   search_start;
  } alloc_req_t;

  typedef struct packed {
    err_t            error_code;
    logic [PA_W-1:0] alloc_addr;
    logic            success;
  } alloc_rsp_t;

  typedef struct {
    alloc_req_t req;
    alloc_rsp_t rsp;
  } pending_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = OP_ALLOC;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Model of the block table
  int                  n_blocks = 0;
  logic [HW_W-1:0]     water = '0;
  logic [PA_W-1:0]     tbl_start    [MAX_BLOCKS];
  logic [PA_W-1:0]     tbl_size     [MAX_BLOCKS];
  logic [KIND_W-1:0]   tbl_kind     [MAX_BLOCKS];
  logic [VA_W-1:0]     tbl_map_virt [MAX_BLOCKS];
  logic [PA_W-1:0]     tbl_bind_len [MAX_BLOCKS];
  logic [PM_W-1:0]     tbl_prot_mode[MAX_BLOCKS];

  pending_t   pending_req_q[$];
  alloc_rsp_t due_rsp_q[$];
  int         fail_count = 0;

  phys_memory_bump_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [PA_W-1:0] rand40();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[PA_W-1:0];
  endfunction

  function automatic logic [VA_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[VA_W-1:0];
  endfunction

  // Round the high-water mark up to the alignment; zero alignment acts as one
  function automatic logic [END_W-1:0] aligned_start(logic [PA_W-1:0] align);
    logic [END_W-1:0] al;
    logic [END_W-1:0] rem;
    al  = (align == '0) ? END_W'(1) : END_W'(align);
    rem = END_W'(water) % al;
    return (rem != '0) ? END_W'(water) - rem + al : END_W'(water);
  endfunction

  // Predict one result word and commit the table update
  function automatic alloc_rsp_t predict_allocator(alloc_req_t r);
    logic [END_W-1:0] pos;
    logic [END_W-1:0] fin;
    logic [HW_W-1:0]  lim;
    alloc_rsp_t       rs;
    bit               hit;
    rs.success    = 1'b0;
    rs.alloc_addr = '0;
    rs.error_code = ERR_OK;
    if (r.op == OP_ALLOC) begin
      pos = aligned_start(r.align_bytes);
      fin = pos + END_W'(r.length);
      if (pos < r.search_start || fin > r.search_end) begin
        rs.error_code = ERR_WINDOW;
      end else if (n_blocks >= MAX_BLOCKS) begin
        rs.error_code = ERR_FULL;
      end else begin
        tbl_start[n_blocks]     = pos[PA_W-1:0];
        tbl_size[n_blocks]      = r.length;
        tbl_kind[n_blocks]      = r.mem_kind;
        tbl_map_virt[n_blocks]  = '0;
        tbl_bind_len[n_blocks]  = '0;
        tbl_prot_mode[n_blocks] = '0;
        n_blocks++;
        if (fin > water) water = fin[HW_W-1:0];
        rs.success    = 1'b1;
        rs.alloc_addr = pos[PA_W-1:0];
      end
    end else begin
      rs.error_code = ERR_NOBLOCK;
      hit = 1'b0;
      for (int i = 0; i < n_blocks && !hit; i++) begin
        lim = HW_W'(tbl_start[i]) + HW_W'(tbl_size[i]);
        if (r.phys_probe >= tbl_start[i] && r.phys_probe < lim) begin
          hit = 1'b1;
          if (tbl_map_virt[i] != '0 || tbl_bind_len[i] != '0) begin
            rs.error_code = ERR_MAPPED;
          end else begin
            tbl_map_virt[i]  = r.virt_base;
            tbl_bind_len[i]  = r.length;
            tbl_prot_mode[i] = {r.protection, r.access_mode};
            rs.success       = 1'b1;
            rs.error_code    = ERR_OK;
          end
        end
      end
    end
    return rs;
  endfunction

  // Any request with every field random
  function automatic alloc_req_t noise_req();
    alloc_req_t r;
    r.op           = ($urandom_range(0, 1) == 0) ? OP_ALLOC : OP_MAP;
    r.access_mode  = MODE_W'($urandom());
    r.protection   = PROT_W'($urandom());
    r.phys_probe   = rand40();
    r.virt_base    = rand48();
    r.mem_kind     = KIND_W'($urandom());
    r.align_bytes  = rand40();
    r.length       = rand40();
    r.search_end   = rand40();
    r.search_start = rand40();
    return r;
  endfunction

  // Allocate with a window around the aligned start; broken now and then
  function automatic alloc_req_t shaped_alloc();
    alloc_req_t       r;
    logic [END_W-1:0] pos;
    logic [END_W-1:0] lim;
    r    = noise_req();
    r.op = OP_ALLOC;
    case ($urandom_range(0, 5))
      0:       r.align_bytes = '0;
      1:       r.align_bytes = PA_W'($urandom_range(1, 3));
      2:       r.align_bytes = PA_W'(1) << $urandom_range(0, 12);
      3:       r.align_bytes = PA_W'($urandom_range(1, 100));
      default: r.align_bytes = PA_W'($urandom_range(1, 65536));
    endcase
    case ($urandom_range(0, 31))
      0:       r.length = '0;
      1:       r.length = rand40() >> $urandom_range(1, 8);
      default: r.length = PA_W'($urandom_range(1, 8192));
    endcase
    pos = aligned_start(r.align_bytes);
    lim = pos + r.length + END_W'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4096));
    r.search_start = (pos > END_W'(PA_MAX)) ? PA_MAX
                   : PA_W'(END_W'(rand40()) % (pos + 1));
    r.search_end   = (lim > END_W'(PA_MAX)) ? PA_MAX : lim[PA_W-1:0];
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0 && pos < END_W'(PA_MAX))
        r.search_start = PA_W'(pos + 1);
      else if (pos + r.length != '0 && pos + r.length <= END_W'(PA_MAX) + 1)
        r.search_end = PA_W'(pos + r.length - 1);
    end
    return r;
  endfunction

  // Map aimed at a known block, at its edges, or anywhere
  function automatic alloc_req_t shaped_map();
    alloc_req_t r;
    int         idx;
    r    = noise_req();
    r.op = OP_MAP;
    if (n_blocks > 0 && $urandom_range(0, 4) != 0) begin
      idx = $urandom_range(0, n_blocks - 1);
      case ($urandom_range(0, 7))
        0:       r.phys_probe = tbl_start[idx] + tbl_size[idx];
        1:       r.phys_probe = tbl_start[idx] - 1;
        default: r.phys_probe = (tbl_size[idx] == '0) ? tbl_start[idx]
                              : tbl_start[idx] + rand40() % tbl_size[idx];
      endcase
    end
    case ($urandom_range(0, 9))
      0:       begin r.virt_base = '0; r.length = '0; end
      1:       r.virt_base = '0;
      2:       r.length = '0;
      3:       r.access_mode = '0;
      default: r.length = PA_W'($urandom_range(1, 65536));
    endcase
    return r;
  endfunction

  task automatic queue_req(alloc_req_t r);
    pending_t p;
    p.req = r;
    p.rsp = predict_allocator(r);
    pending_req_q = {pending_req_q, p};
  endtask

  task automatic dir_alloc(logic [PA_W-1:0] s_start, logic [PA_W-1:0] s_end,
                           logic [PA_W-1:0] len, logic [PA_W-1:0] align,
                           logic [KIND_W-1:0] kind);
    alloc_req_t r;
    r              = '0;
    r.op           = OP_ALLOC;
    r.search_start = s_start;
    r.search_end   = s_end;
    r.length       = len;
    r.align_bytes  = align;
    r.mem_kind     = kind;
    queue_req(r);
  endtask

  task automatic dir_map(logic [PA_W-1:0] probe, logic [VA_W-1:0] virt,
                         logic [PA_W-1:0] len, logic [PROT_W-1:0] prot,
                         logic [MODE_W-1:0] mode);
    alloc_req_t r;
    r             = '0;
    r.op          = OP_MAP;
    r.phys_probe  = probe;
    r.virt_base   = virt;
    r.length      = len;
    r.protection  = prot;
    r.access_mode = mode;
    queue_req(r);
  endtask

  // Hold until every queued word is sent and every result has come back
  task automatic wait_drain();
    do @(posedge clk);
    while (pending_req_q.size() != 0 || in_tvalid || due_rsp_q.size() != 0);
  endtask

  // Stimulus
  initial begin
    logic [END_W-1:0] pos;
    int               tries;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part
    dir_map('0, VA_W'(1), PA_W'(1), '0, '0);                 // empty table
    dir_alloc('0, PA_MAX, PA_W'(64), '0, 4'hF);              // zero alignment
    dir_alloc('0, PA_MAX, '0, PA_W'(1), 4'h1);               // zero-length block
    dir_map(PA_W'(64), VA_W'(5), PA_W'(5), 8'h11, 4'h1);     // hits no block
    dir_alloc('0, PA_MAX, PA_W'(256), PA_W'(4096), 4'h2);
    pos = aligned_start(PA_W'(3));
    dir_alloc(PA_W'(pos), PA_W'(pos + 16), PA_W'(16), PA_W'(3), 4'h3);
    pos = aligned_start(PA_W'(7));
    dir_alloc(PA_W'(pos + 1), PA_MAX, PA_W'(8), PA_W'(7), 4'h4);
    pos = aligned_start('0);
    dir_alloc('0, PA_W'(pos + 31), PA_W'(32), '0, 4'h5);     // end one past window
    dir_alloc('0, PA_MAX, PA_MAX, PA_MAX, 4'hA);             // wide sum
    dir_alloc(PA_MAX, PA_MAX, '0, '0, 4'h6);
    dir_map('0, '0, '0, 8'h22, 4'h2);                        // stays unmapped
    dir_map(PA_W'(63), VA_MAX, PA_MAX, 8'hFF, 4'hF);
    dir_map(PA_W'(32), VA_W'(9), PA_W'(9), 8'h33, 4'h3);     // already mapped
    dir_map(PA_W'(4096), '0, PA_W'(5), 8'h44, '0);           // mapped by length
    dir_map(PA_W'(4351), VA_W'(1), '0, 8'h55, 4'h5);
    dir_map(PA_W'(4352), VA_W'(2), PA_W'(2), 8'h66, 4'h6);
    dir_map(PA_MAX, VA_W'(3), PA_W'(3), 8'h77, 4'h7);
    pos = aligned_start('0);
    dir_alloc(PA_W'(pos), PA_W'(pos), '0, '0, 4'h7);         // exact zero window
    wait_drain();

    // Random part, with a full drain every few chunks
    for (int chunk = 0; chunk < 19; chunk++) begin
      for (int k = 0; k < 100; k++) begin
        case ($urandom_range(0, 19))
          0, 1:       queue_req(shaped_alloc());
          2, 3, 4:    queue_req(noise_req());
          default:    queue_req(shaped_map());
        endcase
      end
      if (chunk % 5 == 4) wait_drain();
    end

    // Fill the table, then hit the full and window errors on a full table
    tries = 0;
    while (n_blocks < MAX_BLOCKS && tries < 300) begin
      pos = aligned_start('0);
      if (pos + 16 <= END_W'(PA_MAX))
        dir_alloc('0, PA_MAX, PA_W'($urandom_range(0, 16)), '0, KIND_W'($urandom()));
      tries++;
    end
    dir_alloc('0, PA_MAX, '0, '0, 4'h8);
    dir_alloc(PA_MAX, PA_MAX, PA_W'(1), PA_W'(1), 4'h9);
    for (int k = 0; k < 20; k++) queue_req(shaped_map());

    wait_drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Driver: bursts of words with random gaps
  int       burst_left = 1;
  int       gap_left = 0;
  pending_t next_word;
  alloc_rsp_t sent_rsp;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) due_rsp_q = {due_rsp_q, sent_rsp};
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_req_q.size() != 0) begin
          next_word = pending_req_q.pop_front();
          sent_rsp  = next_word.rsp;
          in_tdata  <= next_word.req[IN_TDATA_W-1:0];
          in_tuser  <= next_word.req.op;
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check result words and stall on a changing pattern
  int         rdy_mode = 0;
  int         mode_left = 0;
  int         phase = 0;
  alloc_rsp_t got;
  alloc_rsp_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.success    = out_tdata[0];
        got.alloc_addr = out_tdata[PA_W:1];
        got.error_code = err_t'(out_tdata[PA_W+ERR_W:PA_W+1]);
        if (due_rsp_q.size() == 0) begin
          $error("result word with no request outstanding: %0h", out_tdata);
          fail_count++;
        end else begin
          want = due_rsp_q.pop_front();
          if (got.success !== want.success) begin
            $error("success expected %0h actual %0h", want.success, got.success);
            fail_count++;
          end
          if (got.alloc_addr !== want.alloc_addr) begin
            $error("alloc_addr expected %0h actual %0h", want.alloc_addr, got.alloc_addr);
            fail_count++;
          end
          if (got.error_code !== want.error_code) begin
            $error("error_code expected %0h actual %0h", want.error_code, got.error_code);
            fail_count++;
          end
        end
      end
      // Pick a new stall pattern when the current one runs out
      if (mode_left == 0) begin
        rdy_mode  = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      phase++;
      case (rdy_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= phase[2];
      endcase
    end
  end

  // Timeout
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: phys_memory_bump_allocator_top.f
rtl/pmba_pkg.sv
rtl/pmba_rem_unit.sv
rtl/phys_memory_bump_allocator_top.sv
tb/sv/testbench.sv
